### hw/rtl/decimal_text_to_octal_digits_unit_macros.svh
// Assertion macros shared by the decimal text to octal digits RTL.
`ifndef DECIMAL_TEXT_TO_OCTAL_DIGITS_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_OCTAL_DIGITS_UNIT_MACROS_SVH

// Clocked property check on i_clk, disabled while i_rst_n is low.
`define DTOO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define DTOO_NEVER(lbl, cond, msg) `DTOO_ASSERT(lbl, !(cond), msg)

`endif

### hw/rtl/dtoo_pkg.sv
// Package with types and constants of the decimal text to octal digits unit.
`timescale 1ns / 1ps

package dtoo_pkg;

    // Character codes.
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Status codes of a result.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_NUMBER = 3'd1;
    localparam logic [2:0] ST_LEAD_ZERO = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_BAD_MINUS = 3'd4;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd5;

    // Magnitude is limited to 2^31 - 1, so it fits 31 bits exactly.
    localparam int MAG_W      = 31;
    localparam int CNT_W      = 4;
    localparam int OCT_GROUPS = (MAG_W + 2) / 3;
    localparam int OCT_W      = 3 * OCT_GROUPS;
    localparam int IDX_W      = $clog2(OCT_GROUPS);

    // Line queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One finished line as handed from front to back.
    typedef struct packed {
        logic [2:0]       status;
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } t_line_rec;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One result item.
    typedef struct packed {
        logic [2:0] status;
        logic       is_minus;
        logic [2:0] octal_digit;
        logic       last;
    } t_result;

endpackage

### hw/rtl/dtoo_if.sv
// Request channel interfaces for characters in and results out.
`timescale 1ns / 1ps

interface dtoo_ch_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface dtoo_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       is_minus;
    logic [2:0] octal_digit;
    logic       last;

    modport source (output valid, output status, output is_minus, output octal_digit,
                    output last, input ready);
    modport sink (input valid, input status, input is_minus, input octal_digit,
                  input last, output ready);
endinterface

### hw/rtl/dtoo_fifo.sv
// Short queue of finished lines between the front and the back.
`timescale 1ns / 1ps
`include "decimal_text_to_octal_digits_unit_macros.svh"

module dtoo_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dtoo_pkg::t_line_rec i_rec,
    input  logic                i_pop,
    output dtoo_pkg::t_line_rec o_rec,
    output dtoo_pkg::t_q_stat   o_stat
);

    dtoo_pkg::t_line_rec                 r_mem [dtoo_pkg::Q_DEPTH];
    logic [dtoo_pkg::Q_PTR_W-1:0]        r_wr_ptr;
    logic [dtoo_pkg::Q_PTR_W-1:0]        r_rd_ptr;
    logic [dtoo_pkg::Q_CNT_W-1:0]        r_count;
    logic [dtoo_pkg::Q_PTR_W-1:0]        n_wr_ptr;
    logic [dtoo_pkg::Q_PTR_W-1:0]        n_rd_ptr;

    // Pointers wrap at the queue depth.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == dtoo_pkg::Q_PTR_W'(dtoo_pkg::Q_DEPTH - 1))
                   ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == dtoo_pkg::Q_PTR_W'(dtoo_pkg::Q_DEPTH - 1))
                   ? '0 : r_rd_ptr + 1'b1;
    end

    // Pointer and fill count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Line storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    assign o_rec        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == dtoo_pkg::Q_CNT_W'(dtoo_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    `DTOO_NEVER(a_fifo_count_range, r_count > dtoo_pkg::Q_CNT_W'(dtoo_pkg::Q_DEPTH), "queue count beyond depth")
    `DTOO_NEVER(a_fifo_push_full, i_push && o_stat.full, "line pushed into a full queue")
    `DTOO_NEVER(a_fifo_pop_empty, i_pop && o_stat.empty, "line popped from an empty queue")

endmodule

### hw/rtl/dtoo_front.sv
// Front end: takes characters, builds the number and closes each line.
`timescale 1ns / 1ps

module dtoo_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dtoo_ch_if.sink             i_ch_req,
    input  dtoo_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output dtoo_pkg::t_line_rec o_rec
);

    logic [dtoo_pkg::MAG_W-1:0] r_mag;
    logic [dtoo_pkg::CNT_W-1:0] r_cnt;
    logic                       r_neg;
    logic                       r_first_zero;
    logic [2:0]                 r_err;

    logic [dtoo_pkg::MAG_W-1:0] n_mag;
    logic [dtoo_pkg::CNT_W-1:0] n_cnt;
    logic                       n_neg;
    logic                       n_first_zero;
    logic [2:0]                 n_err;

    logic                       w_take;
    logic                       w_is_nl;
    logic                       w_is_minus;
    logic                       w_is_digit;
    logic [3:0]                 w_digit;
    logic [dtoo_pkg::MAG_W+3:0] w_sum;
    logic                       w_overflow;
    logic [2:0]                 w_status;

    // Only a newline needs queue space, but ready stays independent of the data.
    assign i_ch_req.ready = !i_q_stat.full;

    // Character classification and the times-ten accumulate.
    always_comb begin
        w_take     = i_ch_req.valid && i_ch_req.ready;
        w_is_nl    = (i_ch_req.ch == dtoo_pkg::CHAR_NL);
        w_is_minus = (i_ch_req.ch == dtoo_pkg::CHAR_MINUS);
        w_is_digit = (i_ch_req.ch >= dtoo_pkg::CHAR_ZERO) &&
                     (i_ch_req.ch <= dtoo_pkg::CHAR_NINE);
        w_digit    = 4'(i_ch_req.ch - dtoo_pkg::CHAR_ZERO);
        w_sum      = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
                     + (dtoo_pkg::MAG_W + 4)'(w_digit);
        w_overflow = |w_sum[dtoo_pkg::MAG_W+3:dtoo_pkg::MAG_W];
    end

    // Line status in priority order: recorded error, leading zero, no digits.
    always_comb begin
        if (r_err != dtoo_pkg::ST_OK) begin
            w_status = r_err;
        end else if (r_cnt > dtoo_pkg::CNT_W'(1) && r_first_zero) begin
            w_status = dtoo_pkg::ST_LEAD_ZERO;
        end else if (r_cnt == '0) begin
            w_status = dtoo_pkg::ST_NO_NUMBER;
        end else begin
            w_status = dtoo_pkg::ST_OK;
        end
    end

    // A newline hands the finished line to the queue.
    always_comb begin
        o_push          = w_take && w_is_nl;
        o_rec.status    = w_status;
        o_rec.negative  = r_neg;
        o_rec.magnitude = r_mag;
    end

    // Line state update.
    always_comb begin
        n_mag        = r_mag;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        n_first_zero = r_first_zero;
        n_err        = r_err;
        if (w_take) begin
            if (w_is_nl) begin
                n_mag        = '0;
                n_cnt        = '0;
                n_neg        = 1'b0;
                n_first_zero = 1'b0;
                n_err        = dtoo_pkg::ST_OK;
            end else if (r_err == dtoo_pkg::ST_OK) begin
                if (w_is_minus) begin
                    if (!r_neg && r_cnt == '0) begin
                        n_neg = 1'b1;
                    end else begin
                        n_err = dtoo_pkg::ST_BAD_MINUS;
                    end
                end else if (w_is_digit) begin
                    if (r_cnt == '0 && w_digit == 4'd0) begin
                        n_first_zero = 1'b1;
                    end
                    if (w_overflow) begin
                        n_err = dtoo_pkg::ST_TOO_LARGE;
                    end else begin
                        n_mag = w_sum[dtoo_pkg::MAG_W-1:0];
                        if (r_cnt != '1) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end else begin
                    n_err = dtoo_pkg::ST_BAD_CHAR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag        <= '0;
            r_cnt        <= '0;
            r_neg        <= 1'b0;
            r_first_zero <= 1'b0;
            r_err        <= dtoo_pkg::ST_OK;
        end else begin
            r_mag        <= n_mag;
            r_cnt        <= n_cnt;
            r_neg        <= n_neg;
            r_first_zero <= n_first_zero;
            r_err        <= n_err;
        end
    end

endmodule

### hw/rtl/dtoo_back.sv
// Back end: turns each queued line into status or octal digit results.
`timescale 1ns / 1ps
`include "decimal_text_to_octal_digits_unit_macros.svh"

module dtoo_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtoo_pkg::t_q_stat   i_q_stat,
    input  dtoo_pkg::t_line_rec i_rec,
    output logic                o_pop,
    dtoo_res_if.source          o_res
);

    typedef enum logic {
        BACK_IDLE,
        BACK_DIGITS
    } t_back_state;

    t_back_state                r_state;
    logic [dtoo_pkg::MAG_W-1:0] r_mag;
    logic [dtoo_pkg::IDX_W-1:0] r_idx;
    logic                       r_res_valid;
    dtoo_pkg::t_result          r_res;

    t_back_state                n_state;
    logic [dtoo_pkg::MAG_W-1:0] n_mag;
    logic [dtoo_pkg::IDX_W-1:0] n_idx;
    logic                       n_res_valid;
    dtoo_pkg::t_result          n_res;

    logic                       w_free;
    logic [dtoo_pkg::OCT_W-1:0] w_head_pad;
    logic [dtoo_pkg::OCT_W-1:0] w_cur_pad;
    logic [dtoo_pkg::IDX_W-1:0] w_top_idx;
    logic [2:0]                 w_digit;

    // Top nonzero octal group of the queued line and the current digit.
    always_comb begin
        w_head_pad = {{(dtoo_pkg::OCT_W - dtoo_pkg::MAG_W){1'b0}}, i_rec.magnitude};
        w_cur_pad  = {{(dtoo_pkg::OCT_W - dtoo_pkg::MAG_W){1'b0}}, r_mag};
        w_top_idx  = '0;
        w_digit    = '0;
        for (int g = 0; g < dtoo_pkg::OCT_GROUPS; g++) begin
            if (w_head_pad[3*g +: 3] != 3'd0) begin
                w_top_idx = dtoo_pkg::IDX_W'(g);
            end
            if (r_idx == dtoo_pkg::IDX_W'(g)) begin
                w_digit = w_cur_pad[3*g +: 3];
            end
        end
    end

    // Result sequencing; the output register frees when the receiver takes it.
    always_comb begin
        w_free      = !r_res_valid || o_res.ready;
        n_state     = r_state;
        n_mag       = r_mag;
        n_idx       = r_idx;
        n_res_valid = r_res_valid && !o_res.ready;
        n_res       = r_res;
        o_pop       = 1'b0;
        case (r_state)
            BACK_IDLE: begin
                if (!i_q_stat.empty && w_free) begin
                    o_pop = 1'b1;
                    if (i_rec.status != dtoo_pkg::ST_OK) begin
                        n_res       = '{status: i_rec.status, is_minus: 1'b0,
                                        octal_digit: 3'd0, last: 1'b1};
                        n_res_valid = 1'b1;
                    end else if (i_rec.magnitude == '0) begin
                        // A lone zero gives the digit zero and never a sign.
                        n_res       = '{status: dtoo_pkg::ST_OK, is_minus: 1'b0,
                                        octal_digit: 3'd0, last: 1'b1};
                        n_res_valid = 1'b1;
                    end else begin
                        n_state = BACK_DIGITS;
                        n_mag   = i_rec.magnitude;
                        n_idx   = w_top_idx;
                        if (i_rec.negative) begin
                            n_res       = '{status: dtoo_pkg::ST_OK, is_minus: 1'b1,
                                            octal_digit: 3'd0, last: 1'b0};
                            n_res_valid = 1'b1;
                        end
                    end
                end
            end
            BACK_DIGITS: begin
                if (w_free) begin
                    n_res       = '{status: dtoo_pkg::ST_OK, is_minus: 1'b0,
                                    octal_digit: w_digit, last: (r_idx == '0)};
                    n_res_valid = 1'b1;
                    if (r_idx == '0) begin
                        n_state = BACK_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = BACK_IDLE;
            end
        endcase
    end

    // State and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BACK_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
        r_mag <= n_mag;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.status      = r_res.status;
    assign o_res.is_minus    = r_res.is_minus;
    assign o_res.octal_digit = r_res.octal_digit;
    assign o_res.last        = r_res.last;

    `DTOO_ASSERT(a_back_minus_form, r_res_valid && r_res.is_minus |-> r_res.status == dtoo_pkg::ST_OK && !r_res.last, "minus result malformed")
    `DTOO_ASSERT(a_back_status_last, r_res_valid && r_res.status != dtoo_pkg::ST_OK |-> r_res.last, "status result not last")
    `DTOO_ASSERT(a_back_pop_yields, o_pop |=> r_res_valid || r_state == BACK_DIGITS, "popped line produced nothing")

endmodule

### hw/rtl/decimal_text_to_octal_digits_unit.sv
// Top level of the decimal text to octal digits unit.
`timescale 1ns / 1ps
// Usage:
// i_ch_req carries one ASCII character per request. Characters build an
// optionally signed decimal number; a newline closes the line.
// o_res carries results: for each line either one status result, or an
// optional minus result followed by the octal digits, most significant
// first. The final result of each line has last set.
// Throughput: one character per cycle while the line queue is not full.
// The back end pops a new line only after the current one's last result.
// A queue of two closed lines sits between the character front end and
// the result back end, so input keeps flowing while digits are emitted;
// ready drops only while that queue holds two lines.
// The first result of a line is registered once its newline has passed
// the line queue; an unsigned nonzero value first loads the digit state.
// Reset (i_rst_n low at a clock edge) clears the line state, empties
// the queue and drops the output valid; no clearing pass follows.
// When the receiver stalls, the held result stays stable in the output
// register and the back end waits; the front end keeps taking characters
// until the queue fills.

module decimal_text_to_octal_digits_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtoo_ch_if.sink    i_ch_req,
    dtoo_res_if.source o_res
);

    logic                w_push;
    logic                w_pop;
    dtoo_pkg::t_line_rec w_push_rec;
    dtoo_pkg::t_line_rec w_head_rec;
    dtoo_pkg::t_q_stat   w_q_stat;

    // Character front end.
    dtoo_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ch_req (i_ch_req),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_rec    (w_push_rec)
    );

    // Line queue.
    dtoo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_rec   (w_head_rec),
        .o_stat  (w_q_stat)
    );

    // Result back end.
    dtoo_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_rec    (w_head_rec),
        .o_pop    (w_pop),
        .o_res    (o_res)
    );

endmodule

### tb/decimal_text_to_octal_digits_unit_tb.sv
// Self-checking testbench for the decimal text to octal digits unit.
`timescale 1ns / 1ps

module decimal_text_to_octal_digits_unit_tb;

    localparam int unsigned NUM_LIMIT   = 32'h7FFF_FFFF;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 100;
    localparam int          TAIL_CYCLES = 20;

    // Predicts the results of each line and checks them in order.
    class octal_line_scoreboard;
        dtoo_pkg::t_result          pending_results[$];
        int unsigned                errors;
        logic [dtoo_pkg::MAG_W-1:0] value_acc;
        logic [dtoo_pkg::CNT_W-1:0] digit_cnt;
        logic                       negative;
        logic                       lead_zero;
        logic [2:0]                 err_code;

        function void clear_line();
            value_acc = '0;
            digit_cnt = '0;
            negative  = 1'b0;
            lead_zero = 1'b0;
            err_code  = dtoo_pkg::ST_OK;
        endfunction

        function void add_result(logic [2:0] st, logic mi, logic [2:0] dg, logic la);
            dtoo_pkg::t_result r;
            r.status      = st;
            r.is_minus    = mi;
            r.octal_digit = dg;
            r.last        = la;
            pending_results.push_back(r);
        endfunction

        // Updates the line state with one accepted character.
        function void note_char(logic [7:0] c);
            int unsigned d;
            int unsigned v;
            int          n_oct;
            logic [2:0]  st;
            if (c == dtoo_pkg::CHAR_NL) begin
                st = dtoo_pkg::ST_OK;
                if (err_code != dtoo_pkg::ST_OK)
                    st = err_code;
                else if (digit_cnt > 1 && lead_zero)
                    st = dtoo_pkg::ST_LEAD_ZERO;
                else if (digit_cnt == 0)
                    st = dtoo_pkg::ST_NO_NUMBER;

                if (st != dtoo_pkg::ST_OK) begin
                    add_result(st, 1'b0, 3'd0, 1'b1);
                end else if (value_acc == 0) begin
                    // A lone zero never carries a sign.
                    add_result(dtoo_pkg::ST_OK, 1'b0, 3'd0, 1'b1);
                end else begin
                    n_oct = 0;
                    for (v = value_acc; v != 0; v = v >> 3)
                        n_oct++;
                    if (negative)
                        add_result(dtoo_pkg::ST_OK, 1'b1, 3'd0, 1'b0);
                    for (int i = n_oct; i > 0; i--)
                        add_result(dtoo_pkg::ST_OK, 1'b0, 3'(value_acc >> (3 * (i - 1))),
                                   i == 1);
                end
                clear_line();
            end else if (err_code == dtoo_pkg::ST_OK) begin
                if (c == dtoo_pkg::CHAR_MINUS) begin
                    if (!negative && digit_cnt == 0)
                        negative = 1'b1;
                    else
                        err_code = dtoo_pkg::ST_BAD_MINUS;
                end else if (c >= dtoo_pkg::CHAR_ZERO && c <= dtoo_pkg::CHAR_NINE) begin
                    d = 32'(c - dtoo_pkg::CHAR_ZERO);
                    if (digit_cnt == 0 && d == 0)
                        lead_zero = 1'b1;
                    // The digit that would overflow is dropped.
                    if (value_acc > (NUM_LIMIT - d) / 10) begin
                        err_code = dtoo_pkg::ST_TOO_LARGE;
                    end else begin
                        value_acc = dtoo_pkg::MAG_W'(value_acc * 10 + d);
                        if (digit_cnt != 4'd15)
                            digit_cnt++;
                    end
                end else begin
                    err_code = dtoo_pkg::ST_BAD_CHAR;
                end
            end
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(dtoo_pkg::t_result got);
            dtoo_pkg::t_result exp_r;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d is_minus %0d octal_digit %0d last %0d",
                       got.status, got.is_minus, got.octal_digit, got.last);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.is_minus !== exp_r.is_minus) begin
                $error("is_minus: expected %0d, actual %0d", exp_r.is_minus, got.is_minus);
                errors++;
            end
            if (got.octal_digit !== exp_r.octal_digit) begin
                $error("octal_digit: expected %0d, actual %0d",
                       exp_r.octal_digit, got.octal_digit);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $error("last: expected %0d, actual %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   items_sent;

    dtoo_ch_if  ch_if ();
    dtoo_res_if res_if ();

    octal_line_scoreboard sb = new();
    dtoo_pkg::t_result    seen_res;

    decimal_text_to_octal_digits_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ch_req (ch_if),
        .o_res    (res_if)
    );

    // Clock generation.
    always #4 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("decimal_text_to_octal_digits_unit: mismatch");
            $finish;
        end
    end

    // The receiver stalls at random.
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result monitor.
    assign seen_res = {res_if.status, res_if.is_minus, res_if.octal_digit, res_if.last};

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(seen_res);
    end

    // Sends one character request, with random idle cycles ahead of it.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct) begin
            ch_if.valid <= 1'b0;
            ch_if.ch    <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        ch_if.valid <= 1'b1;
        ch_if.ch    <= c;
        @(posedge i_clk);
        while (!ch_if.ready)
            @(posedge i_clk);
        items_sent++;
        sb.note_char(c);
    endtask

    // Sends a text followed by a newline.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(dtoo_pkg::CHAR_NL);
    endtask

    // Builds one random line, mostly well formed, and sends it.
    task automatic send_random_line();
        logic [7:0] chars[$];
        string      s;
        longint     v;
        int         kind;
        int         n;
        int         pos;
        kind = $urandom_range(99);
        if (kind < 45) begin
            // Ordinary number, mostly short.
            n = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 10);
            chars.push_back(8'(dtoo_pkg::CHAR_ZERO +
                               ((n == 1) ? $urandom_range(9) : $urandom_range(1, 9))));
            for (int i = 1; i < n; i++)
                chars.push_back(8'(dtoo_pkg::CHAR_ZERO + $urandom_range(9)));
        end else if (kind < 58) begin
            // Around the largest value.
            v = 64'd2147483647 + $urandom_range(40) - 30;
            s = $sformatf("%0d", v);
            for (int i = 0; i < s.len(); i++)
                chars.push_back(s[i]);
        end else if (kind < 64) begin
            // Ten to sixteen digits, mostly too large to fit.
            n = $urandom_range(10, 16);
            chars.push_back(8'(dtoo_pkg::CHAR_ZERO + $urandom_range(1, 9)));
            for (int i = 1; i < n; i++)
                chars.push_back(8'(dtoo_pkg::CHAR_ZERO + $urandom_range(9)));
        end else if (kind < 74) begin
            // Leading zero, including a lone zero.
            chars.push_back(dtoo_pkg::CHAR_ZERO);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++)
                chars.push_back(8'(dtoo_pkg::CHAR_ZERO + $urandom_range(9)));
        end else if (kind < 80) begin
            // No digits at all.
            n = $urandom_range(2);
            for (int i = 0; i < n; i++)
                chars.push_back(dtoo_pkg::CHAR_MINUS);
        end else begin
            // Raw noise over the whole byte range.
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                chars.push_back(8'($urandom_range(255)));
        end

        if (kind < 74 && $urandom_range(99) < 35)
            chars.push_front(dtoo_pkg::CHAR_MINUS);

        // Occasionally break the line with a stray minus or byte.
        if ($urandom_range(99) < 10) begin
            pos = $urandom_range(chars.size());
            chars.insert(pos, ($urandom_range(1) == 1) ? dtoo_pkg::CHAR_MINUS
                                                       : 8'($urandom_range(255)));
        end

        foreach (chars[i])
            send_char(chars[i]);
        send_char(dtoo_pkg::CHAR_NL);
    endtask

    // Holds the sender until every predicted result has come back.
    task automatic wait_results_drained();
        ch_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Main sequence.
    initial begin
        int target;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cycles         = 0;
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        ch_if.valid    = 1'b0;
        ch_if.ch       = 8'd0;
        res_if.ready   = 1'b0;
        sb.errors      = 0;
        sb.clear_line();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines: empty, zeros, extremes, errors and their priority.
        send_text("");
        send_text("0");
        send_text("-0");
        send_text("00");
        send_text("-2147483647");
        send_text("2147483648");
        send_text("5-");
        send_char(8'hFF);
        send_char(dtoo_pkg::CHAR_MINUS);
        send_char(dtoo_pkg::CHAR_NL);
        wait_results_drained();

        // Random phases with different idle patterns.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 70; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 70; end
                default: begin src_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_random_line();
            wait_results_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("decimal_text_to_octal_digits_unit: match");
        else
            $display("decimal_text_to_octal_digits_unit: mismatch");
        $finish;
    end

endmodule
